FILE: design/lxc_pkg.sv
package lxc_pkg;

    // default sizes
    localparam int MAX_LAYERS_DEF = 8;
    localparam int WORD_BITS_DEF  = 32;

    // configuration port
    localparam int CFG_W  = 32;
    localparam int CNT_W  = 4;
    localparam int IDX_W  = 3;

    typedef logic [IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SEED        = 3'd0;
    localparam t_cfg_idx CFG_MULTIPLIER  = 3'd1;
    localparam t_cfg_idx CFG_INCREMENT   = 3'd2;
    localparam t_cfg_idx CFG_MODULUS     = 3'd3;
    localparam t_cfg_idx CFG_LAYER_COUNT = 3'd4;

    localparam logic [CFG_W-1:0] RST_SEED       = 32'd0;
    localparam logic [CFG_W-1:0] RST_MULTIPLIER = 32'd20011;
    localparam logic [CFG_W-1:0] RST_INCREMENT  = 32'd10007;
    localparam logic [CFG_W-1:0] RST_MODULUS    = 32'd100003;
    localparam logic [CNT_W-1:0] RST_LAYERS     = 4'd5;

    // parameter words handed down the chain: seed, multiplier, increment, modulus
    typedef logic [1:0] t_field_idx;
    localparam t_field_idx FLD_SEED = 2'd0;
    localparam t_field_idx FLD_MUL  = 2'd1;
    localparam t_field_idx FLD_INC  = 2'd2;
    localparam t_field_idx FLD_MOD  = 2'd3;

    // per cell control
    typedef struct packed {
        logic       start;
        logic       restore;
        logic       capture;
        t_field_idx cap_idx;
    } t_cell_ctl;

    // per cell status
    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } t_cell_sts;

    typedef enum logic [2:0] {
        C_IDLE,
        C_PREP,
        C_DIV,
        C_FIN,
        C_DONE
    } t_cell_state;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DRV_REST,
        S_DRV_STEP,
        S_DRV_WAIT,
        S_RESTORE_ALL,
        S_RUN_START,
        S_RUN_WAIT
    } t_top_state;

endpackage

FILE: design/lxc_cell.sv
module lxc_cell #(
    parameter int WORD_BITS = lxc_pkg::WORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lxc_pkg::t_cell_ctl    i_ctl,
    input  logic [WORD_BITS-1:0]  i_prev,
    output logic [WORD_BITS-1:0]  o_val,
    output lxc_pkg::t_cell_sts    o_sts
);

    localparam int CW = $clog2(WORD_BITS) + 1;

    lxc_pkg::t_cell_state r_state, n_state;

    logic [WORD_BITS-1:0] r_seed, r_mul, r_inc, r_mod, r_val;
    logic [WORD_BITS-1:0] r_t, r_quo, r_rem;
    logic                 r_neg;
    logic [CW-1:0]        r_cnt;

    logic [WORD_BITS-1:0] den;
    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   diff;
    logic                 ge;
    logic                 mod_zero;

    // restoring divider datapath, one quotient bit per cycle
    assign mod_zero = (r_mod == '0);
    assign den      = r_mod[WORD_BITS-1] ? (~r_mod + 1'b1) : r_mod;
    assign trial    = {r_rem, r_quo[WORD_BITS-1]};
    assign diff     = trial - {1'b0, den};
    assign ge       = (trial >= {1'b0, den});

    // step sequencing
    always_comb begin
        n_state = r_state;
        case (r_state)
            lxc_pkg::C_IDLE: if (i_ctl.start) n_state = lxc_pkg::C_PREP;
            lxc_pkg::C_PREP: n_state = mod_zero ? lxc_pkg::C_DONE : lxc_pkg::C_DIV;
            lxc_pkg::C_DIV:  if (r_cnt == '0) n_state = lxc_pkg::C_FIN;
            lxc_pkg::C_FIN:  n_state = lxc_pkg::C_DONE;
            lxc_pkg::C_DONE: n_state = lxc_pkg::C_IDLE;
            default:         n_state = lxc_pkg::C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lxc_pkg::C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // parameter capture from the neighbor and the step datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            case (i_ctl.cap_idx)
                lxc_pkg::FLD_SEED: r_seed <= i_prev;
                lxc_pkg::FLD_MUL:  r_mul  <= i_prev;
                lxc_pkg::FLD_INC:  r_inc  <= i_prev;
                lxc_pkg::FLD_MOD:  r_mod  <= i_prev;
                default:           r_seed <= i_prev;
            endcase
        end
        if (i_ctl.restore) begin
            r_val <= r_seed;
        end
        case (r_state)
            lxc_pkg::C_IDLE: begin
                if (i_ctl.start) r_t <= r_val * r_mul + r_inc;
            end
            lxc_pkg::C_PREP: begin
                r_neg <= r_t[WORD_BITS-1];
                r_quo <= r_t[WORD_BITS-1] ? (~r_t + 1'b1) : r_t;
                r_rem <= '0;
                r_cnt <= CW'(WORD_BITS - 1);
                if (mod_zero) r_val <= r_t;
            end
            lxc_pkg::C_DIV: begin
                r_rem <= ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
                r_quo <= {r_quo[WORD_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
            end
            lxc_pkg::C_FIN: begin
                r_val <= r_neg ? (~r_rem + 1'b1) : r_rem;
            end
            default: begin
            end
        endcase
    end

    assign o_val       = r_val;
    assign o_sts.busy  = (r_state != lxc_pkg::C_IDLE);
    assign o_sts.done  = (r_state == lxc_pkg::C_DONE);
    assign o_sts.zero  = mod_zero;

endmodule

FILE: design/layered_lcg_xor_stream_cipher_top.sv
// each accepted byte steps every active layer once through the per-cell restoring divider;
//   a zero-modulus layer skips the divide; with no active layer the byte passes through
// first byte of a message adds parameter derivation: MAX_LAYERS x 4 chained steps
// a new byte is taken only after the last one finishes, and also while a result waits
// reset: synchronous active low, clears control, config to defaults, no message open
module layered_lcg_xor_stream_cipher_top #(
    parameter int MAX_LAYERS = lxc_pkg::MAX_LAYERS_DEF,
    parameter int WORD_BITS  = lxc_pkg::WORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  lxc_pkg::t_cfg_idx          i_cfg_idx,
    input  logic [lxc_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_last_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [7:0]                 o_out_byte,
    output logic                       o_out_last,
    output logic                       o_zero_modulus
);

    localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int AW = $clog2(MAX_LAYERS + 1);

    lxc_pkg::t_top_state r_state, n_state;

    logic [lxc_pkg::CFG_W-1:0] r_seed, r_mul, r_inc, r_mod;
    logic [lxc_pkg::CNT_W-1:0] r_layers;

    logic                 r_open, r_fault;
    logic [LW-1:0]        r_d;
    lxc_pkg::t_field_idx  r_j;
    logic [7:0]           r_byte;
    logic                 r_last;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last, r_out_zero;

    lxc_pkg::t_cell_ctl   ctl   [MAX_LAYERS];
    lxc_pkg::t_cell_sts   sts   [MAX_LAYERS];
    logic [WORD_BITS-1:0] val   [MAX_LAYERS];
    logic [WORD_BITS-1:0] prev  [MAX_LAYERS];
    logic [MAX_LAYERS-1:0] act_mask, busy_v, zero_v, cap_v;

    logic [AW-1:0]        active;
    logic [WORD_BITS-1:0] cfg_word;
    logic                 accept, finish, cur_done;
    logic [7:0]           acc;
    logic                 zero_any;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= lxc_pkg::RST_SEED;
            r_mul    <= lxc_pkg::RST_MULTIPLIER;
            r_inc    <= lxc_pkg::RST_INCREMENT;
            r_mod    <= lxc_pkg::RST_MODULUS;
            r_layers <= lxc_pkg::RST_LAYERS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lxc_pkg::CFG_SEED:        r_seed   <= i_cfg_data;
                lxc_pkg::CFG_MULTIPLIER:  r_mul    <= i_cfg_data;
                lxc_pkg::CFG_INCREMENT:   r_inc    <= i_cfg_data;
                lxc_pkg::CFG_MODULUS:     r_mod    <= i_cfg_data;
                lxc_pkg::CFG_LAYER_COUNT: r_layers <= i_cfg_data[lxc_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // active layer count, saturated
    assign active = (int'(r_layers) > MAX_LAYERS) ? AW'(MAX_LAYERS) : AW'(r_layers);

    // first cell is fed from the config words, sign extended to the word size
    always_comb begin
        case (r_j)
            lxc_pkg::FLD_SEED: cfg_word = WORD_BITS'($signed(r_seed));
            lxc_pkg::FLD_MUL:  cfg_word = WORD_BITS'($signed(r_mul));
            lxc_pkg::FLD_INC:  cfg_word = WORD_BITS'($signed(r_inc));
            lxc_pkg::FLD_MOD:  cfg_word = WORD_BITS'($signed(r_mod));
            default:           cfg_word = WORD_BITS'($signed(r_seed));
        endcase
    end

    assign cur_done = sts[r_d].done;

    // chain of generator cells
    for (genvar k = 0; k < MAX_LAYERS; k++) begin : g_cell
        if (k == 0) begin : g_first
            assign prev[k] = cfg_word;
        end else begin : g_next
            assign prev[k] = val[k-1];
        end

        assign act_mask[k] = (k < int'(active));
        assign busy_v[k]   = sts[k].busy;
        assign zero_v[k]   = sts[k].zero;
        assign cap_v[k]    = ctl[k].capture;

        assign ctl[k].start   = ((r_state == lxc_pkg::S_RUN_START) && act_mask[k]) ||
                                ((r_state == lxc_pkg::S_DRV_STEP) && (int'(r_d) == k));
        assign ctl[k].restore = ((r_state == lxc_pkg::S_DRV_REST) && (int'(r_d) == k)) ||
                                (r_state == lxc_pkg::S_RESTORE_ALL);
        assign ctl[k].capture = ((r_state == lxc_pkg::S_LOAD) && (k == 0)) ||
                                ((r_state == lxc_pkg::S_DRV_WAIT) && cur_done &&
                                 (int'(r_d) + 1 == k));
        assign ctl[k].cap_idx = r_j;

        lxc_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[k]),
            .i_prev  (prev[k]),
            .o_val   (val[k]),
            .o_sts   (sts[k])
        );
    end

    // keystream combine over active layers
    always_comb begin
        acc = r_byte;
        for (int k = 0; k < MAX_LAYERS; k++) begin
            if (act_mask[k]) acc = acc ^ val[k][7:0];
        end
    end
    assign zero_any = |(zero_v & act_mask);

    assign accept = (r_state == lxc_pkg::S_IDLE) && i_in_valid;
    assign finish = (((r_state == lxc_pkg::S_RUN_START) && (active == '0)) ||
                     ((r_state == lxc_pkg::S_RUN_WAIT) && ((busy_v & act_mask) == '0))) &&
                    (!r_out_valid || !i_out_stall);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lxc_pkg::S_IDLE:
                if (i_in_valid) n_state = r_open ? lxc_pkg::S_RUN_START : lxc_pkg::S_LOAD;
            lxc_pkg::S_LOAD:
                if (r_j == lxc_pkg::FLD_MOD) n_state = lxc_pkg::S_DRV_REST;
            lxc_pkg::S_DRV_REST:
                n_state = lxc_pkg::S_DRV_STEP;
            lxc_pkg::S_DRV_STEP:
                n_state = lxc_pkg::S_DRV_WAIT;
            lxc_pkg::S_DRV_WAIT: begin
                if (cur_done) begin
                    if (r_j != lxc_pkg::FLD_MOD)            n_state = lxc_pkg::S_DRV_STEP;
                    else if (int'(r_d) == MAX_LAYERS - 1)   n_state = lxc_pkg::S_RESTORE_ALL;
                    else                                    n_state = lxc_pkg::S_DRV_REST;
                end
            end
            lxc_pkg::S_RESTORE_ALL:
                n_state = lxc_pkg::S_RUN_START;
            lxc_pkg::S_RUN_START:
                if (active == '0) begin
                    if (finish) n_state = lxc_pkg::S_IDLE;
                end else begin
                    n_state = lxc_pkg::S_RUN_WAIT;
                end
            lxc_pkg::S_RUN_WAIT:
                if (finish) n_state = lxc_pkg::S_IDLE;
            default:
                n_state = lxc_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lxc_pkg::S_IDLE;
            r_open      <= 1'b0;
            r_fault     <= 1'b0;
            r_out_valid <= 1'b0;
            r_d         <= '0;
            r_j         <= lxc_pkg::FLD_SEED;
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                lxc_pkg::S_IDLE: begin
                    r_d <= '0;
                    r_j <= lxc_pkg::FLD_SEED;
                end
                lxc_pkg::S_LOAD: r_j <= r_j + 1'b1;
                lxc_pkg::S_DRV_WAIT: begin
                    if (cur_done) begin
                        r_j <= r_j + 1'b1;
                        if (r_j == lxc_pkg::FLD_MOD) r_d <= r_d + 1'b1;
                    end
                end
                lxc_pkg::S_RESTORE_ALL: begin
                    r_fault <= 1'b0;
                    r_open  <= 1'b1;
                end
                default: begin
                end
            endcase
            if (finish) begin
                r_out_valid <= 1'b1;
                r_fault     <= r_fault | zero_any;
                if (r_last) r_open <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
        if (finish) begin
            r_out_byte <= acc;
            r_out_last <= r_last;
            r_out_zero <= r_fault | zero_any;
        end
    end

    assign o_in_stall     = (r_state != lxc_pkg::S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_out_last     = r_out_last;
    assign o_zero_modulus = r_out_zero;

`ifndef SYNTH
    // only one cell takes a parameter word at a time
    a_cap_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cap_v))
        else $error("more than one cell capturing");

    // cells only run while the sequencer waits on them or idles
    a_busy_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy_v != '0) |-> (r_state == lxc_pkg::S_DRV_WAIT || r_state == lxc_pkg::S_RUN_WAIT ||
                            r_state == lxc_pkg::S_IDLE))
        else $error("cell busy outside a wait state");

    // derivation leaves the message open with a clean fault flag
    a_fault_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lxc_pkg::S_RESTORE_ALL) |=> (!r_fault && r_open))
        else $error("fault flag not cleared at message start");

    // a byte of a new message always runs derivation first
    a_derive_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_open) |=> (r_state == lxc_pkg::S_LOAD))
        else $error("new message skipped derivation");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

// predicts the cipher output and matches it against the block's results
class cipher_scoreboard;
    typedef struct {
        logic [7:0] out_byte;
        logic       out_last;
        logic       zero_mod;
    } t_cipher_out;

    t_cipher_out      expected_q[$];
    logic [lxc_pkg::CFG_W-1:0] reg_seed, reg_mult, reg_incr, reg_mod;
    logic [lxc_pkg::CNT_W-1:0] reg_layers;
    logic [31:0]      lay_val[lxc_pkg::MAX_LAYERS_DEF];
    logic [31:0]      lay_mult[lxc_pkg::MAX_LAYERS_DEF];
    logic [31:0]      lay_incr[lxc_pkg::MAX_LAYERS_DEF];
    logic [31:0]      lay_mod[lxc_pkg::MAX_LAYERS_DEF];
    bit               msg_open;
    bit               fault;
    int               errors;

    function new();
        reg_seed   = lxc_pkg::RST_SEED;
        reg_mult   = lxc_pkg::RST_MULTIPLIER;
        reg_incr   = lxc_pkg::RST_INCREMENT;
        reg_mod    = lxc_pkg::RST_MODULUS;
        reg_layers = lxc_pkg::RST_LAYERS;
        msg_open   = 0;
        fault      = 0;
        errors     = 0;
    endfunction

    function void write_reg(lxc_pkg::t_cfg_idx idx, logic [lxc_pkg::CFG_W-1:0] data);
        case (idx)
            lxc_pkg::CFG_SEED:        reg_seed = data;
            lxc_pkg::CFG_MULTIPLIER:  reg_mult = data;
            lxc_pkg::CFG_INCREMENT:   reg_incr = data;
            lxc_pkg::CFG_MODULUS:     reg_mod = data;
            lxc_pkg::CFG_LAYER_COUNT: reg_layers = data[lxc_pkg::CNT_W-1:0];
            default: ;
        endcase
    endfunction

    // one generator step: wrapped x*a+b, truncating signed remainder
    function logic [31:0] lcg_step(logic [31:0] x, logic [31:0] a, logic [31:0] b,
                                   logic [31:0] m, inout bit zero);
        logic [31:0] t, ut, um, r;
        t = x * a + b;
        if (m == 0) begin
            zero = 1;
            return t;
        end
        ut = t[31] ? -t : t;
        um = m[31] ? -m : m;
        r  = ut % um;
        return t[31] ? -r : r;
    endfunction

    // each layer's parameters are the first four outputs of the layer before
    function void derive_layers();
        logic [31:0] p[4];
        logic [31:0] q[4];
        logic [31:0] x;
        bit          unused;
        p[0] = reg_seed;
        p[1] = reg_mult;
        p[2] = reg_incr;
        p[3] = reg_mod;
        unused = 0;
        for (int i = 0; i < lxc_pkg::MAX_LAYERS_DEF; i++) begin
            lay_val[i]  = p[0];
            lay_mult[i] = p[1];
            lay_incr[i] = p[2];
            lay_mod[i]  = p[3];
            x = p[0];
            for (int k = 0; k < 4; k++) begin
                x = lcg_step(x, p[1], p[2], p[3], unused);
                q[k] = x;
            end
            p = q;
        end
    endfunction

    function void note_input(logic [7:0] data, logic last);
        t_cipher_out exp_out;
        int          active;
        bit          zero;
        zero = 0;
        if (!msg_open) begin
            derive_layers();
            fault    = 0;
            msg_open = 1;
        end
        active = (reg_layers > lxc_pkg::MAX_LAYERS_DEF) ? lxc_pkg::MAX_LAYERS_DEF : reg_layers;
        exp_out.out_byte = data;
        for (int i = 0; i < active; i++) begin
            lay_val[i] = lcg_step(lay_val[i], lay_mult[i], lay_incr[i], lay_mod[i], zero);
            exp_out.out_byte ^= lay_val[i][7:0];
        end
        if (zero)
            fault = 1;
        if (last)
            msg_open = 0;
        exp_out.out_last = last;
        exp_out.zero_mod = fault;
        expected_q.push_back(exp_out);
    endfunction

    function void check_result(logic [7:0] got_byte, logic got_last, logic got_zero);
        t_cipher_out exp_out;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result byte=%h last=%b zero=%b",
                         got_byte, got_last, got_zero);
            return;
        end
        exp_out = expected_q.pop_front();
        if (got_byte !== exp_out.out_byte || got_last !== exp_out.out_last ||
            got_zero !== exp_out.zero_mod) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: exp byte=%h last=%b zero=%b, got byte=%h last=%b zero=%b",
                         exp_out.out_byte, exp_out.out_last, exp_out.zero_mod,
                         got_byte, got_last, got_zero);
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module testbench;
    localparam lxc_pkg::t_cfg_idx CFG_UNUSED = 3'd7;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    lxc_pkg::t_cfg_idx          i_cfg_idx;
    logic [lxc_pkg::CFG_W-1:0]  i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [7:0]                 i_data_byte;
    logic                       i_last_byte;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [7:0]                 o_out_byte;
    logic                       o_out_last;
    logic                       o_zero_modulus;

    cipher_scoreboard sb;
    int               stall_mode;

    layered_lcg_xor_stream_cipher_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_out_last     (o_out_last),
        .o_zero_modulus (o_zero_modulus)
    );

    // clock
    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // monitor accepted transactions on both channels
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_input(i_data_byte, i_last_byte);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_byte, o_out_last, o_zero_modulus);
    end

    // receiver stall pattern, mode changed by the stimulus
    always @(posedge i_clk) begin
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(3) == 0);
            default: i_out_stall <= ($urandom_range(3) != 0);
        endcase
    end

    task automatic send_byte(logic [7:0] data, logic last);
        i_in_valid  <= 1'b1;
        i_data_byte <= data;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic idle_gap(int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // wait for the block to drain, then write one register
    task automatic write_reg(lxc_pkg::t_cfg_idx idx, logic [lxc_pkg::CFG_W-1:0] data);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [31:0] seed, logic [31:0] mult, logic [31:0] incr,
                              logic [31:0] modv, logic [3:0] layers);
        write_reg(lxc_pkg::CFG_SEED, seed);
        write_reg(lxc_pkg::CFG_MULTIPLIER, mult);
        write_reg(lxc_pkg::CFG_INCREMENT, incr);
        write_reg(lxc_pkg::CFG_MODULUS, modv);
        write_reg(lxc_pkg::CFG_LAYER_COUNT, {28'd0, layers});
    endtask

    // random messages in bursts; mostly short messages, a few long ones
    task automatic random_bytes(int count);
        int left_in_msg;
        int burst;
        left_in_msg = 0;
        burst = $urandom_range(1, 8);
        stall_mode = $urandom_range(2);
        for (int n = 0; n < count; n++) begin
            if (left_in_msg == 0)
                left_in_msg = ($urandom_range(9) == 0) ? $urandom_range(20, 40)
                                                       : $urandom_range(1, 10);
            send_byte($urandom_range(255), left_in_msg == 1);
            left_in_msg--;
            burst--;
            if (burst == 0) begin
                if ($urandom_range(2) != 0)
                    idle_gap($urandom_range(1, 40));
                burst = $urandom_range(1, 12);
                if ($urandom_range(7) == 0)
                    stall_mode = $urandom_range(2);
            end
        end
        i_in_valid <= 1'b0;
    endtask

    logic [31:0] rnd_mod;

    initial begin
        sb = new();
        stall_mode  = 0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = lxc_pkg::CFG_SEED;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        i_out_stall = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: one-byte message, then a four-byte message with extreme bytes
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        idle_gap(1);

        // zero modulus sets the flag
        set_config(32'd12345, 32'd7, 32'd3, 32'd0, 4'd1);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b1);
        idle_gap(1);

        // most negative value reduced by minus one
        set_config(32'd0, 32'd0, 32'h8000_0000, 32'hFFFF_FFFF, 4'd8);
        send_byte(8'h81, 1'b1);
        idle_gap(1);

        // extreme registers, layer count saturates
        set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 4'd15);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h01, 1'b1);
        idle_gap(1);

        // no active layer, then a write to an unused index
        write_reg(lxc_pkg::CFG_LAYER_COUNT, 32'd0);
        send_byte(8'h3C, 1'b1);
        idle_gap(1);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        write_reg(lxc_pkg::CFG_LAYER_COUNT, 32'hFFFF_FFF3);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h5A, 1'b1);
        idle_gap(1);

        // defaults again, then random settings; phases may end mid-message
        set_config(lxc_pkg::RST_SEED, lxc_pkg::RST_MULTIPLIER, lxc_pkg::RST_INCREMENT,
                   lxc_pkg::RST_MODULUS, lxc_pkg::RST_LAYERS);
        random_bytes(120);
        for (int ph = 0; ph < 7; ph++) begin
            case ($urandom_range(3))
                0: rnd_mod = 32'd0;
                1: rnd_mod = $urandom_range(1, 300);
                2: rnd_mod = -$urandom_range(1, 1000);
                default: rnd_mod = $urandom;
            endcase
            set_config($urandom, $urandom, $urandom, rnd_mod, $urandom_range(15));
            random_bytes(120);
        end

        // drain
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
